// File: hdl/ttl_pkg.sv
// Shared types and constants for the thermistor table linearizer.
package ttl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int TEMP_W      = 24;
  localparam int SCALE_W     = 16;
  localparam int VALUE_W     = IDX_W + FRAC_BITS;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int PROD_W      = VALUE_W + SCALE_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CNT_W-1:0]   ENTRIES_RESET  = CNT_W'(TABLE_DEPTH);
  localparam logic [SCALE_W-1:0] SCALE_RESET    = SCALE_W'(256);
  localparam logic [TEMP_W-1:0]  OVERFLOW_RESET = TEMP_W'(128000);
  localparam logic [TEMP_W-1:0]  INVALID_RESET  = TEMP_W'(128000);

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ENTRIES_USED  = 2'd0,
    REG_SCALE_FACTOR  = 2'd1,
    REG_OVERFLOW_TEMP = 2'd2,
    REG_INVALID_TEMP  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_INTERP  = 2'd0,
    ST_ABOVE   = 2'd1,
    ST_BELOW   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_CONVERT = 2'd1,
    OP_INVALID = 2'd2
  } op_kind_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_FETCH = 3'd1,
    B_WALK  = 3'd2,
    B_DIV   = 3'd3,
    B_MUL   = 3'd4,
    B_DONE  = 3'd5
  } back_state_t;

  // One classified word in the queue between front and back.
  typedef struct packed {
    op_kind_t                 kind;
    logic [IDX_W-1:0]         index;
    logic [SAMPLE_BITS-1:0]   data;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic [CNT_W-1:0]   entries_used;
    logic [SCALE_W-1:0] scale_factor;
    logic [TEMP_W-1:0]  overflow_temp;
    logic [TEMP_W-1:0]  invalid_temp;
  } cfg_t;

endpackage

// File: hdl/ttl_front.sv
// Front end: classifies incoming words and holds them in a short queue.
module ttl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [ttl_pkg::IDX_W-1:0]         entry_index,
  input  logic [15:0]                       entry_value,
  input  logic [ttl_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                              sample_invalid,
  input  logic                              q_pop,
  output ttl_pkg::q_head_t                  q_head
);

  ttl_pkg::q_item_t              queue_mem [ttl_pkg::QUEUE_DEPTH];
  logic [ttl_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ttl_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ttl_pkg::QCNT_W-1:0]    count;
  ttl_pkg::q_item_t              new_item;
  logic                          push;
  logic                          pop;

  always_comb begin
    new_item.index = entry_index;
    if (ttl_pkg::cmd_t'(command) == ttl_pkg::CMD_LOAD) begin
      new_item.kind = ttl_pkg::OP_LOAD;
      new_item.data = ttl_pkg::SAMPLE_BITS'(entry_value);
    end else if (sample_invalid) begin
      new_item.kind = ttl_pkg::OP_INVALID;
      new_item.data = sample;
    end else begin
      new_item.kind = ttl_pkg::OP_CONVERT;
      new_item.data = sample;
    end
  end

  assign busy = (count == ttl_pkg::QCNT_W'(ttl_pkg::QUEUE_DEPTH));
  assign push = start && !busy;
  assign pop  = q_pop && (count != '0);

  assign q_head.valid = (count != '0);
  assign q_head.item  = queue_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ttl_back.sv
// Back end: table memory, table walk, fraction divider and output scaling.
module ttl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ttl_pkg::cfg_t                 cfg,
  input  ttl_pkg::q_head_t              q_head,
  output logic                          q_pop,
  output logic                          done,
  output logic [ttl_pkg::TEMP_W-1:0]    temperature,
  output logic [1:0]                    status
);

  ttl_pkg::back_state_t              state;
  ttl_pkg::back_state_t              state_next;

  logic [ttl_pkg::SAMPLE_BITS-1:0]   tbl_mem [ttl_pkg::TABLE_DEPTH];
  logic [ttl_pkg::IDX_W-1:0]         rd_addr;
  logic [ttl_pkg::SAMPLE_BITS-1:0]   rd_data;

  logic [ttl_pkg::IDX_W-1:0]         idx;
  logic [ttl_pkg::CNT_W-1:0]         n_lim;
  logic [ttl_pkg::SAMPLE_BITS-1:0]   smp;
  logic [ttl_pkg::SAMPLE_BITS-1:0]   prev;
  logic [ttl_pkg::SAMPLE_BITS-1:0]   rem;
  logic [ttl_pkg::SAMPLE_BITS-1:0]   den;
  logic [ttl_pkg::QUO_W-1:0]         quo;
  logic [ttl_pkg::STEP_W-1:0]        step;
  logic [ttl_pkg::VALUE_W-1:0]       value;
  logic [ttl_pkg::TEMP_W-1:0]        res_temp;
  ttl_pkg::status_t                  res_status;

  logic [ttl_pkg::CNT_W-1:0]         n_clamped;
  logic                              hit;
  logic                              last;
  logic                              first;
  logic                              div_last;
  logic [ttl_pkg::SAMPLE_BITS:0]     trial;
  logic                              ge;
  logic [ttl_pkg::QUO_W-1:0]         quo_shift;
  logic [ttl_pkg::PROD_W-1:0]        product;

  // Entry counts outside 2..TABLE_DEPTH are pinned to the nearest bound.
  always_comb begin
    if (cfg.entries_used < ttl_pkg::CNT_W'(2)) begin
      n_clamped = ttl_pkg::CNT_W'(2);
    end else if (cfg.entries_used > ttl_pkg::CNT_W'(ttl_pkg::TABLE_DEPTH)) begin
      n_clamped = ttl_pkg::CNT_W'(ttl_pkg::TABLE_DEPTH);
    end else begin
      n_clamped = cfg.entries_used;
    end
  end

  assign hit      = (smp >= rd_data);
  assign first    = (idx == '0);
  assign last     = ((ttl_pkg::CNT_W'(idx) + 1'b1) == n_lim);
  assign div_last = (step == ttl_pkg::STEP_W'(ttl_pkg::FRAC_BITS));
  assign trial    = (step == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge       = (trial >= {1'b0, den});
  assign quo_shift = {quo[ttl_pkg::QUO_W-2:0], ge};
  assign product  = ttl_pkg::PROD_W'(value) * ttl_pkg::PROD_W'(cfg.scale_factor);

  // Address of the entry whose data the walk sees in the following cycle.
  assign rd_addr = (state == ttl_pkg::B_WALK) ? idx + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (q_pop && (q_head.item.kind == ttl_pkg::OP_LOAD)) begin
      tbl_mem[q_head.item.index] <= ttl_pkg::SAMPLE_BITS'(q_head.item.data);
    end
    rd_data <= tbl_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ttl_pkg::B_IDLE: begin
        if (q_head.valid) begin
          unique case (q_head.item.kind)
            ttl_pkg::OP_LOAD:    state_next = ttl_pkg::B_IDLE;
            ttl_pkg::OP_INVALID: state_next = ttl_pkg::B_DONE;
            ttl_pkg::OP_CONVERT: state_next = ttl_pkg::B_FETCH;
            default:             state_next = ttl_pkg::B_IDLE;
          endcase
        end
      end
      ttl_pkg::B_FETCH: state_next = ttl_pkg::B_WALK;
      ttl_pkg::B_WALK: begin
        if (hit) begin
          state_next = first ? ttl_pkg::B_DONE : ttl_pkg::B_DIV;
        end else if (last) begin
          state_next = ttl_pkg::B_DONE;
        end
      end
      ttl_pkg::B_DIV: begin
        if (div_last) begin
          state_next = ttl_pkg::B_MUL;
        end
      end
      ttl_pkg::B_MUL:  state_next = ttl_pkg::B_DONE;
      ttl_pkg::B_DONE: state_next = ttl_pkg::B_IDLE;
      default:         state_next = ttl_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state == ttl_pkg::B_IDLE) && q_head.valid;
    done        = (state == ttl_pkg::B_DONE);
    temperature = res_temp;
    status      = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttl_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ttl_pkg::B_IDLE: begin
        smp        <= q_head.item.data;
        n_lim      <= n_clamped;
        res_temp   <= cfg.invalid_temp;
        res_status <= ttl_pkg::ST_INVALID;
      end
      ttl_pkg::B_FETCH: begin
        idx <= '0;
      end
      ttl_pkg::B_WALK: begin
        if (hit) begin
          if (first) begin
            res_temp   <= '0;
            res_status <= ttl_pkg::ST_ABOVE;
          end else begin
            rem  <= prev - smp;
            den  <= prev - rd_data;
            step <= '0;
            quo  <= '0;
          end
        end else begin
          prev <= rd_data;
          idx  <= idx + 1'b1;
          if (last) begin
            res_temp   <= cfg.overflow_temp;
            res_status <= ttl_pkg::ST_BELOW;
          end
        end
      end
      ttl_pkg::B_DIV: begin
        // One quotient bit per cycle, integer bit first.
        rem  <= ttl_pkg::SAMPLE_BITS'(ge ? trial - {1'b0, den} : trial);
        quo  <= quo_shift;
        step <= step + 1'b1;
        if (div_last) begin
          value <= {idx - 1'b1, {ttl_pkg::FRAC_BITS{1'b0}}} + ttl_pkg::VALUE_W'(quo_shift);
        end
      end
      ttl_pkg::B_MUL: begin
        res_temp   <= ttl_pkg::TEMP_W'(product >> ttl_pkg::FRAC_BITS);
        res_status <= ttl_pkg::ST_INTERP;
      end
      ttl_pkg::B_DONE: begin
        res_temp <= res_temp;
      end
      default: begin
        res_temp <= res_temp;
      end
    endcase
  end

endmodule

// File: hdl/thermistor_table_linearizer_unit.sv
// Top level of the thermistor table linearizer: configuration registers and core.
//
// The block turns thermistor voltage codes into temperatures in 1/256 degree
// units by walking a table of falling voltage codes and interpolating.
// Input words are offered on start with command, entry_index, entry_value,
// sample and sample_invalid; a word is taken at a clock edge with start high
// and busy low. A load word writes one table entry and returns nothing. A
// convert word returns one result word on temperature and status, marked by
// done for exactly one cycle; the receiver cannot stall, so results are
// never held back.
// The front end classifies each word and places it in a two-word queue, so
// busy rises only when that queue is full. The back end takes words in order.
// A load writes one table entry when the back end takes it. A convert runs
// a fetch, a walk reading one table entry a cycle from the table memory,
// the bit-serial fraction divider, the scale multiply and a done state that
// presents the result; special cases go straight to done, and the walk
// stops early once it finds its entry. The configuration port writes one
// register per cycle with cfg_write; the user is to use it only while the
// block is idle, not enforced by the block. Reset restores the register
// defaults and empties the queue; table contents are undefined until loaded.
module thermistor_table_linearizer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [ttl_pkg::IDX_W-1:0]         entry_index,
  input  logic [15:0]                       entry_value,
  input  logic [ttl_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                              sample_invalid,
  output logic                              done,
  output logic [ttl_pkg::TEMP_W-1:0]        temperature,
  output logic [1:0]                        status,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [ttl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ttl_pkg::cfg_t     cfg;
  ttl_pkg::q_head_t  q_head;
  logic              q_pop;

  // Configuration registers, reloaded with their defaults at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entries_used  <= ttl_pkg::ENTRIES_RESET;
      cfg.scale_factor  <= ttl_pkg::SCALE_RESET;
      cfg.overflow_temp <= ttl_pkg::OVERFLOW_RESET;
      cfg.invalid_temp  <= ttl_pkg::INVALID_RESET;
    end else if (cfg_write) begin
      unique case (ttl_pkg::reg_index_t'(cfg_index))
        ttl_pkg::REG_ENTRIES_USED:  cfg.entries_used  <= ttl_pkg::CNT_W'(cfg_data);
        ttl_pkg::REG_SCALE_FACTOR:  cfg.scale_factor  <= ttl_pkg::SCALE_W'(cfg_data);
        ttl_pkg::REG_OVERFLOW_TEMP: cfg.overflow_temp <= ttl_pkg::TEMP_W'(cfg_data);
        ttl_pkg::REG_INVALID_TEMP:  cfg.invalid_temp  <= ttl_pkg::TEMP_W'(cfg_data);
        default:                    cfg.entries_used  <= cfg.entries_used;
      endcase
    end
  end

  // Front end: takes words and queues them in arrival order.
  ttl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .sample         (sample),
    .sample_invalid (sample_invalid),
    .q_pop          (q_pop),
    .q_head         (q_head)
  );

  // Back end: owns the table, so loads and converts see the table in order.
  ttl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .done        (done),
    .temperature (temperature),
    .status      (status)
  );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the thermistor table linearizer unit.
`timescale 1ns / 100ps

module tb;
  import ttl_pkg::*;

  // The run is stopped here if the block hangs. A correct run is made of
  // about 280 load words, 120 convert words, random gaps with start low
  // and the pauses around configuration writes.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed for trailing load words to drain before the block is
  // treated as idle.
  localparam int SETTLE_CYCLES = 100;
  localparam int WORDS_PER_PHASE = 20;
  localparam int PHASES = 6;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    status_t           st;
  } reading_t;

  typedef struct {
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       val;
    logic [15:0]       smp;
    logic              inv;
    bit                typed;
    reading_t          want;
  } step_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  command = CMD_LOAD;
  logic [IDX_W-1:0]      entry_index = '0;
  logic [15:0]           entry_value = '0;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                  sample_invalid = 1'b0;
  logic                  done;
  logic [TEMP_W-1:0]     temperature;
  logic [1:0]            status;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = REG_ENTRIES_USED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the voltage table and the configuration registers.
  logic [15:0]           volt_tab [TABLE_DEPTH];
  logic [6:0]            span_reg = 7'd64;
  logic [SCALE_W-1:0]    gain_reg = 16'd256;
  logic [TEMP_W-1:0]     over_code = 24'd128000;
  logic [TEMP_W-1:0]     bad_code = 24'd128000;

  reading_t  pending_readings [$];
  step_row_t dir_rows [$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;

  thermistor_table_linearizer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .sample         (sample),
    .sample_invalid (sample_invalid),
    .done           (done),
    .temperature    (temperature),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The entries_used register is clipped to the range 2 to TABLE_DEPTH
  // before the walk.
  function automatic int walk_length();
    int n;
    n = span_reg;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  // Expected temperature and status for one convert word. An invalid flag
  // wins over everything; a sample at or above the first entry reads as
  // zero; otherwise the walk stops at the first entry at or below the
  // sample and interpolates against the entry before it.
  function automatic reading_t linearize(logic [15:0] s, logic inv);
    reading_t r;
    int n;
    int k;
    bit hit;
    longint unsigned num, den, frac, val, t;
    r.temp = over_code;
    r.st = ST_BELOW;
    hit = 1'b0;
    if (inv) begin
      r.temp = bad_code;
      r.st = ST_INVALID;
    end else if (s >= volt_tab[0]) begin
      r.temp = '0;
      r.st = ST_ABOVE;
    end else begin
      n = walk_length();
      for (k = 1; k < n; k++) begin
        if (!hit && s >= volt_tab[k]) begin
          hit = 1'b1;
          num = 64'(volt_tab[k-1]) - 64'(s);
          den = 64'(volt_tab[k-1]) - 64'(volt_tab[k]);
          frac = (num << FRAC_BITS) / den;
          val = (64'(k - 1) << FRAC_BITS) + frac;
          t = (val * 64'(gain_reg)) >> FRAC_BITS;
          if (t > 64'hFF_FFFF) t = 64'hFF_FFFF;
          r.temp = t[TEMP_W-1:0];
          r.st = ST_INTERP;
        end
      end
    end
    return r;
  endfunction

  // Drives one word and returns at the edge that accepts it. A load word
  // updates our table copy; a convert word queues its expected reading.
  // Now and then the word is preceded by a random gap with start low.
  task automatic send_word(cmd_t c, logic [IDX_W-1:0] idx, logic [15:0] val,
                           logic [15:0] smp, logic inv, bit typed, reading_t want);
    if (!quiet && $urandom_range(99, 0) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    entry_index <= idx;
    entry_value <= val;
    sample <= smp;
    sample_invalid <= inv;
    do @(posedge clk); while (busy);
    if (c == CMD_LOAD) begin
      volt_tab[idx] = val;
    end else begin
      pending_readings.push_back(typed ? want : linearize(smp, inv));
    end
  endtask

  task automatic add_row(cmd_t c, logic [IDX_W-1:0] idx, logic [15:0] val,
                         logic [15:0] smp, logic inv, bit typed,
                         logic [TEMP_W-1:0] temp, status_t st);
    step_row_t row;
    row.cmd = c;
    row.idx = idx;
    row.val = val;
    row.smp = smp;
    row.inv = inv;
    row.typed = typed;
    row.want.temp = temp;
    row.want.st = st;
    dir_rows.push_back(row);
  endtask

  // Waits until every expected reading has come back, then lets trailing
  // load words drain, since they return nothing.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on back-to-back cycles; the block is idle.
  task automatic program_regs(logic [6:0] n, logic [15:0] g, logic [23:0] ov,
                              logic [23:0] bd);
    cfg_write <= 1'b1;
    cfg_index <= REG_ENTRIES_USED;
    cfg_data <= 24'(n);
    @(posedge clk);
    cfg_index <= REG_SCALE_FACTOR;
    cfg_data <= 24'(g);
    @(posedge clk);
    cfg_index <= REG_OVERFLOW_TEMP;
    cfg_data <= ov;
    @(posedge clk);
    cfg_index <= REG_INVALID_TEMP;
    cfg_data <= bd;
    @(posedge clk);
    cfg_write <= 1'b0;
    span_reg = n;
    gain_reg = g;
    over_code = ov;
    bad_code = bd;
    @(posedge clk);
  endtask

  // Loads the searched part of the table. Style 0 is a fixed falling line
  // used by the directed words; style 1 is a random falling table, with flat
  // steps allowed; style 2 is random values with no order at all.
  task automatic fill_voltages(int style);
    logic [15:0] vals [TABLE_DEPTH];
    int level;
    int k;
    reading_t none;
    none = '0;
    level = ($urandom_range(3, 0) == 0) ? 65535 : $urandom_range(65535, 20000);
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (style == 0) begin
        vals[k] = 16'(60000 - 900 * k);
      end else if (style == 1) begin
        vals[k] = 16'(level);
        level = level - $urandom_range(2 * level / TABLE_DEPTH + 1, 0);
        if (level < 0) level = 0;
      end else begin
        vals[k] = 16'($urandom);
      end
    end
    for (k = 0; k < walk_length(); k++) begin
      send_word(CMD_LOAD, IDX_W'(k), vals[k], 16'($urandom), 1'($urandom_range(1, 0)),
                1'b0, none);
    end
  endtask

  // One random word. Most are convert words aimed at the searched part of
  // the table, so the walk runs at every depth; the rest are loads that may
  // break the ordering, invalid, random and out-of-table samples.
  task automatic random_word();
    int n;
    int pick;
    int k;
    int lo, hi, floor_v;
    logic [15:0] smp;
    logic inv;
    reading_t none;
    none = '0;
    n = walk_length();
    pick = $urandom_range(99, 0);
    inv = 1'b0;
    smp = 16'($urandom);
    if (pick < 12) begin
      send_word(CMD_LOAD, IDX_W'($urandom), 16'($urandom), smp,
                1'($urandom_range(1, 0)), 1'b0, none);
    end else begin
      if (pick < 20) begin
        inv = 1'b1;
      end else if (pick < 30) begin
        smp = 16'($urandom);
      end else if (pick < 40) begin
        smp = volt_tab[$urandom_range(n - 1, 0)];
      end else if (pick < 47) begin
        smp = 16'($urandom_range(65535, volt_tab[0]));
      end else if (pick < 53) begin
        floor_v = 65535;
        for (k = 0; k < n; k++) if (volt_tab[k] < floor_v) floor_v = volt_tab[k];
        if (floor_v > 0) smp = 16'($urandom_range(floor_v - 1, 0));
      end else begin
        k = $urandom_range(n - 1, 1);
        lo = volt_tab[k];
        hi = volt_tab[k-1];
        smp = 16'($urandom_range(hi, lo));
      end
      send_word(CMD_CONVERT, IDX_W'($urandom), 16'($urandom), smp, inv, 1'b0, none);
    end
  endtask

  // Results cannot be held off, so every strobe is checked at the edge
  // that ends its cycle against the oldest expected reading.
  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result word temperature %0d status %0d", $time,
                 temperature, status);
        errors++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (temperature !== exp_r.temp) begin
          $display("%0t: temperature expected %0d actual %0d", $time, exp_r.temp,
                   temperature);
          errors++;
        end
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int p;
    int w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words run with reset defaults against the falling line
    // 60000 - 900*k: invalid flag, samples above, at and below the table,
    // exact entry hits, the extremes of the stored values, and an entry
    // pushed out of order so the walk skips over it.
    fill_voltages(0);
    add_row(CMD_CONVERT, 0, 0, 16'h1234, 1'b1, 1, 24'd128000, ST_INVALID);
    add_row(CMD_CONVERT, 0, 0, 16'hFFFF, 1'b1, 1, 24'd128000, ST_INVALID);
    add_row(CMD_CONVERT, 0, 0, 16'hFFFF, 1'b0, 1, 24'd0, ST_ABOVE);
    add_row(CMD_CONVERT, 0, 0, 16'd60000, 1'b0, 1, 24'd0, ST_ABOVE);
    add_row(CMD_CONVERT, 0, 0, 16'd59100, 1'b0, 1, 24'd256, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'd59999, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'd59550, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'd3300, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'd3299, 1'b0, 1, 24'd128000, ST_BELOW);
    add_row(CMD_CONVERT, 0, 0, 16'd0, 1'b0, 1, 24'd128000, ST_BELOW);
    add_row(CMD_CONVERT, 0, 0, 16'd30000, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_LOAD, 6'd0, 16'hFFFF, 16'd0, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'hFFFF, 1'b0, 1, 24'd0, ST_ABOVE);
    add_row(CMD_CONVERT, 0, 0, 16'hFFFE, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_LOAD, 6'd63, 16'h0000, 16'd0, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'd0, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_LOAD, 6'd5, 16'd62000, 16'd0, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'd56000, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'hAAAA, 1'b0, 0, 24'd0, ST_INTERP);
    add_row(CMD_CONVERT, 0, 0, 16'h5555, 1'b0, 0, 24'd0, ST_INTERP);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].smp,
                dir_rows[i].inv, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each with its own register setting and a fresh table.
    // Walk lengths cover the minimum, the full table and the values that
    // are clipped on either side; the scale covers zero and full range.
    // One phase sends words back to back with no gaps to keep busy high.
    for (p = 0; p < PHASES; p++) begin
      settle_block();
      case (p)
        0: program_regs(7'd2, 16'd0, 24'd0, 24'hFF_FFFF);
        1: program_regs(7'd64, 16'hFFFF, 24'hFF_FFFF, 24'd0);
        2: program_regs(7'd0, 16'd256, 24'($urandom), 24'($urandom));
        3: program_regs(7'd1, 16'($urandom), 24'($urandom), 24'($urandom));
        4: program_regs(7'd127, 16'($urandom), 24'($urandom), 24'($urandom));
        5: program_regs(7'd65, 16'($urandom), 24'($urandom), 24'($urandom));
        default: program_regs(7'($urandom_range(64, 2)), 16'($urandom), 24'($urandom),
                              24'($urandom));
      endcase
      quiet = (p == 4);
      fill_voltages(($urandom_range(3, 0) == 0) ? 2 : 1);
      for (w = 0; w < WORDS_PER_PHASE; w++) random_word();
      quiet = 1'b0;
    end

    settle_block();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ttl_pkg.sv
hdl/ttl_front.sv
hdl/ttl_back.sv
hdl/thermistor_table_linearizer_unit.sv
sim/tb.sv
